// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define BIST_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define BIST_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/bist_pkg.sv =====
package bist_pkg;

  localparam int SET_DEPTH = 16;
  localparam int CNT_W     = $clog2(SET_DEPTH + 1);
  localparam int IDX_W     = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int KEY_W     = 64;
  localparam int ID_W      = 32;
  localparam int CFG_W     = 32;

  typedef logic [1:0]       opcode_t;
  typedef logic [1:0]       set_sel_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [ID_W-1:0]  id_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic             reg_idx_t;
  typedef logic [CFG_W-1:0] cfg_data_t;

  localparam opcode_t OP_ADD    = 2'd0;
  localparam opcode_t OP_REMOVE = 2'd1;
  localparam opcode_t OP_QUERY  = 2'd2;

  localparam set_sel_t SEL_CONN  = 2'd0;
  localparam set_sel_t SEL_GRAPH = 2'd1;
  localparam set_sel_t SEL_ID    = 2'd2;

  localparam reg_idx_t REG_IGNORE_ALL  = 1'b0;
  localparam reg_idx_t REG_RESERVED_ID = 1'b1;

  typedef struct packed {
    logic load;
    logic cmp;
    logic exec;
  } cmd_t;

endpackage

// ===== rtl/bist_if.sv =====
interface bist_in_if;
  logic               valid;
  logic               ready;
  bist_pkg::opcode_t  opcode;
  bist_pkg::set_sel_t set_select;
  bist_pkg::key_t     key;

  modport source (output valid, output opcode, output set_select, output key, input ready);
  modport sink   (input valid, input opcode, input set_select, input key, output ready);
endinterface

interface bist_out_if;
  logic valid;
  logic ready;
  logic status;
  logic is_member;

  modport source (output valid, output status, output is_member, input ready);
  modport sink   (input valid, input status, input is_member, output ready);
endinterface

// ===== rtl/bounded_ignore_set_table_core.sv =====
// Three small key sets (connection handles, graph handles, 32-bit ids) of
// bist_pkg::SET_DEPTH entries each, with add, remove and query words on the
// input channel and one status/is_member word per input on the output channel.
// An input word is captured, then its key is compared in parallel against
// the selected set, then the swap-remove or append write is made and the
// result registered; the next word is taken the cycle after, so no new word
// is taken before the prior one is through, and a stalled output holds the
// block in its write step until the prior result is taken. Configuration
// writes (ignore_all at index 0, reserved id at index 1) are taken any
// cycle and should be made while idle. Set counts clear on reset; entries
// are never used above the count.
module bounded_ignore_set_table_core (
  input  logic                clk,
  input  logic                rst_n,
  bist_in_if.sink             in_ch,
  bist_out_if.source          out_ch,
  input  logic                cfg_we,
  input  bist_pkg::reg_idx_t  cfg_index,
  input  bist_pkg::cfg_data_t cfg_wdata
);
  import bist_pkg::*;

  cmd_t cmd;

  bist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  bist_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .opcode     (in_ch.opcode),
    .set_select (in_ch.set_select),
    .key        (in_ch.key),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .status     (out_ch.status),
    .is_member  (out_ch.is_member)
  );

endmodule

// ===== rtl/bist_ctrl.sv =====
module bist_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output bist_pkg::cmd_t cmd
);
  import bist_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/bist_datapath.sv =====
module bist_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  bist_pkg::cmd_t      cmd,
  input  bist_pkg::opcode_t   opcode,
  input  bist_pkg::set_sel_t  set_select,
  input  bist_pkg::key_t      key,
  input  logic                cfg_we,
  input  bist_pkg::reg_idx_t  cfg_index,
  input  bist_pkg::cfg_data_t cfg_wdata,
  output logic                status,
  output logic                is_member
);
  import bist_pkg::*;

  key_t     conn_r  [SET_DEPTH];
  key_t     graph_r [SET_DEPTH];
  id_t      id_r    [SET_DEPTH];
  cnt_t     conn_cnt_r, graph_cnt_r, id_cnt_r;

  logic     ignore_all_r;
  id_t      reserved_r;

  opcode_t  op_r;
  set_sel_t sel_r;
  key_t     key_r;

  logic     found_r, reject_r, forced_r;
  idx_t     pos_r, last_idx_r;
  key_t     last_r;
  cnt_t     cnt_q_r;

  logic     status_r, member_r;

  // compare stage
  cnt_t     cur_cnt, cnt_dec;
  key_t     cur_ent [SET_DEPTH];
  logic     hit_found;
  idx_t     hit_pos;
  logic     cur_reject;

  // execute stage
  logic     wr_en;
  idx_t     wr_idx;
  key_t     wr_data;
  cnt_t     cnt_nxt;
  logic     ex_status, ex_member;

  always_comb begin
    cur_cnt    = '0;
    cur_reject = 1'b1;
    for (int i = 0; i < SET_DEPTH; i++) begin
      cur_ent[i] = '0;
    end
    unique case (sel_r)
      SEL_CONN: begin
        cur_cnt    = conn_cnt_r;
        cur_reject = 1'b0;
        for (int i = 0; i < SET_DEPTH; i++) cur_ent[i] = conn_r[i];
      end
      SEL_GRAPH: begin
        cur_cnt    = graph_cnt_r;
        cur_reject = 1'b0;
        for (int i = 0; i < SET_DEPTH; i++) cur_ent[i] = graph_r[i];
      end
      SEL_ID: begin
        cur_cnt    = id_cnt_r;
        cur_reject = (key_r[ID_W-1:0] == reserved_r);
        for (int i = 0; i < SET_DEPTH; i++) cur_ent[i] = {{(KEY_W-ID_W){1'b0}}, id_r[i]};
      end
      default: ;
    endcase

    hit_found = 1'b0;
    hit_pos   = '0;
    for (int i = SET_DEPTH - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < cur_cnt) && (cur_ent[i] == key_r)) begin
        hit_found = 1'b1;
        hit_pos   = IDX_W'(i);
      end
    end
    cnt_dec = cur_cnt - CNT_W'(1);
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_idx    = pos_r;
    wr_data   = key_r;
    cnt_nxt   = cnt_q_r;
    ex_status = 1'b1;
    ex_member = 1'b0;
    if (!reject_r) begin
      unique case (op_r)
        OP_ADD: begin
          if (found_r) begin
            ex_status = 1'b0;
          end else if (cnt_q_r != CNT_W'(SET_DEPTH)) begin
            ex_status = 1'b0;
            wr_en     = 1'b1;
            wr_idx    = cnt_q_r[IDX_W-1:0];
            cnt_nxt   = cnt_q_r + CNT_W'(1);
          end
        end
        OP_REMOVE: begin
          if (found_r) begin
            ex_status = 1'b0;
            wr_en     = (pos_r != last_idx_r);
            wr_data   = last_r;
            cnt_nxt   = cnt_q_r - CNT_W'(1);
          end
        end
        OP_QUERY: begin
          ex_status = 1'b0;
          ex_member = forced_r || found_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_cnt_r   <= '0;
      graph_cnt_r  <= '0;
      id_cnt_r     <= '0;
      ignore_all_r <= 1'b0;
      reserved_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IGNORE_ALL:  ignore_all_r <= cfg_wdata[0];
          REG_RESERVED_ID: reserved_r   <= cfg_wdata[ID_W-1:0];
          default: ;
        endcase
      end
      if (cmd.exec) begin
        unique case (sel_r)
          SEL_CONN:  conn_cnt_r  <= cnt_nxt;
          SEL_GRAPH: graph_cnt_r <= cnt_nxt;
          SEL_ID:    id_cnt_r    <= cnt_nxt;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      unique case (sel_r)
        SEL_CONN:  conn_r[wr_idx]  <= wr_data;
        SEL_GRAPH: graph_r[wr_idx] <= wr_data;
        SEL_ID:    id_r[wr_idx]    <= wr_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= opcode;
      sel_r <= set_select;
      key_r <= (set_select == SEL_ID) ? {{(KEY_W-ID_W){1'b0}}, key[ID_W-1:0]} : key;
    end
    if (cmd.cmp) begin
      found_r    <= hit_found;
      pos_r      <= hit_pos;
      cnt_q_r    <= cur_cnt;
      last_idx_r <= cnt_dec[IDX_W-1:0];
      last_r     <= cur_ent[cnt_dec[IDX_W-1:0]];
      reject_r   <= cur_reject;
      forced_r   <= ignore_all_r && (sel_r != SEL_GRAPH);
    end
    if (cmd.exec) begin
      status_r <= ex_status;
      member_r <= ex_member;
    end
  end

  assign status    = status_r;
  assign is_member = member_r;

endmodule

// ===== rtl/bist_checker.sv =====
`include "assert_macros.svh"

module bist_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_status,
  input logic out_is_member
);

  `BIST_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "out word dropped")
  `BIST_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable({out_status, out_is_member}), "out word changed")
  `BIST_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready ##1 !in_ready, "accepted during work")
  `BIST_ASSERT(a_member_ok, clk, rst_n, out_valid && out_is_member |-> !out_status, "member with fail")
  `BIST_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid, "out valid after reset")

endmodule

bind bounded_ignore_set_table_core bist_checker u_bist_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_is_member (out_ch.is_member)
);
